>>> design/vtx_control_frame_builder_assert.svh
// Assertion macros used by the checker file.
`ifndef VTX_CONTROL_FRAME_BUILDER_ASSERT_SVH
`define VTX_CONTROL_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define VCFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define VCFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> design/vtxcfb_pkg.sv
package vtxcfb_pkg;

    localparam logic [7:0] CRC_POLY = 8'hD5;
    localparam logic [7:0] SYNC_A   = 8'hAA;
    localparam logic [7:0] SYNC_B   = 8'h55;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    // item kind
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // byte position within the current input item
    typedef enum logic [2:0] {
        ST_DATA,    // sync A for a start item, the data byte for a payload item
        ST_SYNC_B,
        ST_CODE,
        ST_LEN,
        ST_CRC
    } t_step;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((v & CRC_MSB) != 8'h00) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

>>> design/vtx_control_frame_builder.sv
// Accepted items are held in the item register, then go out via the result register.
// Throughput: one result byte per cycle while the output is not stalled; a start item
// yields four bytes (five for an empty payload, with the CRC), a payload byte one (two
// when it closes the frame with the CRC), and a dropped payload byte none.
// Reset: synchronous, active low; clears the frame state, the sequencer and both valids.
module vtx_control_frame_builder
    import vtxcfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_cmd,
    input  logic [6:0] i_command_code,
    input  logic [7:0] i_payload_length,
    input  logic [7:0] i_payload_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_frame_last
);

    // held input item
    logic       r_item_valid, n_item_valid;
    logic       r_cmd, n_cmd;
    logic [6:0] r_code, n_code;
    logic [7:0] r_len, n_len;
    logic [7:0] r_pb, n_pb;
    t_step      r_step, n_step;

    // frame state
    logic [7:0] r_crc, n_crc;
    logic [7:0] r_rem, n_rem;
    logic       r_open, n_open;

    // result register
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_run_last, n_run_last;
    logic       r_frame_last, n_frame_last;

    logic       out_free;
    logic       emit;
    logic       item_done;
    logic [7:0] e_byte;
    logic       e_last;
    logic       e_crc;
    logic       accept;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = r_item_valid && !item_done;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        n_step    = r_step;
        n_crc     = r_crc;
        n_rem     = r_rem;
        n_open    = r_open;
        emit      = 1'b0;
        item_done = 1'b0;
        e_byte    = r_pb;
        e_last    = 1'b0;
        e_crc     = 1'b0;

        if (r_item_valid) begin
            if (r_cmd == CMD_PAYLOAD && !r_open) begin
                item_done = 1'b1;   // no frame open: drop
            end else if (out_free) begin
                emit = 1'b1;
                unique case (r_step)
                    ST_DATA: begin
                        if (r_cmd == CMD_START) begin
                            e_byte = SYNC_A;
                            n_crc  = crc_update(8'h00, SYNC_A);
                            n_open = 1'b1;
                            n_rem  = r_len;
                            n_step = ST_SYNC_B;
                        end else begin
                            e_byte = r_pb;
                            n_crc  = crc_update(r_crc, r_pb);
                            n_rem  = r_rem - 8'd1;
                            if (r_rem == 8'd1) begin
                                n_step = ST_CRC;
                            end else begin
                                e_last = 1'b1;
                            end
                        end
                    end
                    ST_SYNC_B: begin
                        e_byte = SYNC_B;
                        n_crc  = crc_update(r_crc, SYNC_B);
                        n_step = ST_CODE;
                    end
                    ST_CODE: begin
                        e_byte = {r_code, 1'b1};
                        n_crc  = crc_update(r_crc, {r_code, 1'b1});
                        n_step = ST_LEN;
                    end
                    ST_LEN: begin
                        e_byte = r_len;
                        n_crc  = crc_update(r_crc, r_len);
                        if (r_len == 8'd0) begin
                            n_step = ST_CRC;
                        end else begin
                            e_last = 1'b1;
                        end
                    end
                    ST_CRC: begin
                        e_byte = r_crc;
                        e_crc  = 1'b1;
                        e_last = 1'b1;
                        n_crc  = 8'h00;
                        n_rem  = 8'h00;
                        n_open = 1'b0;
                    end
                    default: begin
                        n_step = ST_DATA;
                    end
                endcase
                item_done = e_last;
            end
        end

        if (item_done) begin
            n_step = ST_DATA;
        end
    end

    always_comb begin
        n_item_valid = r_item_valid;
        n_cmd        = r_cmd;
        n_code       = r_code;
        n_len        = r_len;
        n_pb         = r_pb;
        if (accept) begin
            n_item_valid = 1'b1;
            n_cmd        = i_cmd;
            n_code       = i_command_code;
            n_len        = i_payload_length;
            n_pb         = i_payload_byte;
        end else if (item_done) begin
            n_item_valid = 1'b0;
        end

        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_run_last   = r_run_last;
        n_frame_last = r_frame_last;
        if (out_free) begin
            n_out_valid = emit;
            if (emit) begin
                n_out_byte   = e_byte;
                n_run_last   = e_last;
                n_frame_last = e_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_step       <= ST_DATA;
            r_crc        <= 8'h00;
            r_rem        <= 8'h00;
            r_open       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_item_valid <= n_item_valid;
            r_step       <= n_step;
            r_crc        <= n_crc;
            r_rem        <= n_rem;
            r_open       <= n_open;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_code       <= n_code;
        r_len        <= n_len;
        r_pb         <= n_pb;
        r_out_byte   <= n_out_byte;
        r_run_last   <= n_run_last;
        r_frame_last <= n_frame_last;
    end

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_run_last   = r_run_last;
    assign o_frame_last = r_frame_last;

endmodule

>>> design/vtxcfb_checker.sv
`include "vtx_control_frame_builder_assert.svh"

module vtxcfb_checker
    import vtxcfb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_run_last,
    input logic       o_frame_last
);

    // stalled result transaction holds
    `VCFB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out_byte) && $stable(o_run_last) && $stable(o_frame_last))

    // the CRC always ends the results of its item
    `VCFB_ASSERT_IMPL(a_crc_ends_item, i_clk, i_rst_n, o_valid && o_frame_last, o_run_last)

    // after a closed frame the next byte, if present next cycle, opens a new frame
    `VCFB_ASSERT_NEXT(a_after_crc, i_clk, i_rst_n, o_valid && !i_stall && o_frame_last, !o_valid || (o_out_byte == SYNC_A && !o_frame_last))

endmodule

bind vtx_control_frame_builder vtxcfb_checker u_checker (.*);
